FILE: rtl/bste_pkg.sv
// ----------------------------------------------------------------------------
// bste_pkg
// Shared widths, result codes and the control/status bundles that pass
// between the size-table controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bste_pkg;

    // Fixed field widths of the request and response
    localparam int ADDR_W   = 16;
    localparam int NBYTES_W = 16;
    localparam int LOG_W    = 5;
    localparam int STATUS_W = 2;

    // Request commands
    localparam logic CMD_REGISTER   = 1'b0;
    localparam logic CMD_UNREGISTER = 1'b1;

    // Response status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_REG    = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // latch the request and start the table read
        logic eval;      // decode the request and latch the fill plan
        logic fill_wr;   // write one slot of the object
        logic sweep_wr;  // write one slot of the reset clearing pass
        logic cnt_clr;   // return the slot counter to zero
        logic cnt_inc;   // advance the slot counter
        logic load_out;  // move the result into the response register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fault;       // request refused, nothing to write
        logic fill_last;   // counter is on the last slot of the object
        logic sweep_last;  // counter is on the last slot of the table
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/bste_if.sv
// ----------------------------------------------------------------------------
// bste_req_if / bste_rsp_if
// Valid/ready channels carrying requests into the size-table engine and
// responses out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface bste_req_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [bste_pkg::ADDR_W-1:0]       address;
    logic [bste_pkg::NBYTES_W-1:0]     num_bytes;

    modport source (output valid, output cmd, output address, output num_bytes,
                    input ready);
    modport sink   (input valid, input cmd, input address, input num_bytes,
                    output ready);
endinterface

interface bste_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [bste_pkg::STATUS_W-1:0]     status;
    logic [bste_pkg::LOG_W-1:0]        size_log;
    logic [bste_pkg::ADDR_W-1:0]       base_address;

    modport source (output valid, output status, output size_log,
                    output base_address, input ready);
    modport sink   (input valid, input status, input size_log,
                    input base_address, output ready);
endinterface

`default_nettype wire

FILE: rtl/bounds_size_table_engine.sv
// ----------------------------------------------------------------------------
// bounds_size_table_engine
// Power-of-two object size table: register and unregister objects by slot.
// ----------------------------------------------------------------------------
// Each request is handled on its own. A register or unregister that changes
// the table passes from acceptance through decode, then writes one table slot
// per cycle through the single write port of the size table, then hands off
// to the response register. A refused register or an unregister of a free
// slot goes straight from decode to the hand-off. Intake reopens in the cycle
// after the load. After reset every slot of the table is swept to zero, one
// slot per cycle; req.ready stays low until the sweep is done. A finished
// response waits in its own register, so the next request is taken while it
// is still pending.
`default_nettype none

module bounds_size_table_engine #(
    parameter int ADDR_BITS = 16,
    parameter int SLOT_LOG  = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bste_req_if.sink      req,
    bste_rsp_if.source    rsp
);

    bste_pkg::ctrl_cmd_t  ctl;
    bste_pkg::dp_status_t sts;

    bste_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    bste_dp #(
        .ADDR_BITS (ADDR_BITS),
        .SLOT_LOG  (SLOT_LOG)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .req_cmd          (req.cmd),
        .req_address      (req.address),
        .req_num_bytes    (req.num_bytes),
        .rsp_status       (rsp.status),
        .rsp_size_log     (rsp.size_log),
        .rsp_base_address (rsp.base_address)
    );

endmodule

`default_nettype wire

FILE: rtl/bste_ram.sv
// ----------------------------------------------------------------------------
// bste_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bste_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/bste_ctrl.sv
// ----------------------------------------------------------------------------
// bste_ctrl
// Sequencer of the size-table engine: clearing pass after reset, request
// intake, decode, slot-by-slot fill and hand-off to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bste_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output      logic                   req_ready,
    output      logic                   rsp_valid,
    input  wire logic                   rsp_ready,
    output      bste_pkg::ctrl_cmd_t    ctl,
    input  wire bste_pkg::dp_status_t   sts
);

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_FILL  = 5'b01000,
        ST_POST  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // Next-state and command decode
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                ctl.sweep_wr = 1'b1;
                ctl.cnt_inc  = 1'b1;
                if (sts.sweep_last)
                begin
                    ctl.cnt_inc = 1'b0;
                    ctl.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                ctl.eval    = 1'b1;
                ctl.cnt_clr = 1'b1;
                state_next  = sts.fault ? ST_POST : ST_FILL;
            end
            ST_FILL:
            begin
                ctl.fill_wr = 1'b1;
                ctl.cnt_inc = 1'b1;
                if (sts.fill_last)
                begin
                    ctl.cnt_inc = 1'b0;
                    ctl.cnt_clr = 1'b1;
                    state_next  = ST_POST;
                end
            end
            ST_POST:
            begin
                // Wait until the response register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // Response valid: set on load, drop once taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/bste_dp.sv
// ----------------------------------------------------------------------------
// bste_dp
// Datapath of the size-table engine: request latch, size and alignment
// decode, slot counter, the size table itself and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bste_dp #(
    parameter int ADDR_BITS = 16,
    parameter int SLOT_LOG  = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bste_pkg::ctrl_cmd_t             ctl,
    output      bste_pkg::dp_status_t            sts,
    input  wire logic                            req_cmd,
    input  wire logic [bste_pkg::ADDR_W-1:0]     req_address,
    input  wire logic [bste_pkg::NBYTES_W-1:0]   req_num_bytes,
    output      logic [bste_pkg::STATUS_W-1:0]   rsp_status,
    output      logic [bste_pkg::LOG_W-1:0]      rsp_size_log,
    output      logic [bste_pkg::ADDR_W-1:0]     rsp_base_address
);

    localparam int AW = bste_pkg::ADDR_W;
    localparam int LW = bste_pkg::LOG_W;
    // Addresses never reach past the request field, so neither does the table
    localparam int EFF_BITS = (ADDR_BITS < AW) ? ADDR_BITS : AW;
    localparam int IDX_BITS = (EFF_BITS - SLOT_LOG < 1) ? 1 : EFF_BITS - SLOT_LOG;
    localparam int DEPTH    = 1 << IDX_BITS;
    localparam logic [AW-1:0] ADDR_MASK = (ADDR_BITS >= AW) ? {AW{1'b1}} :
                                          AW'((32'd1 << ADDR_BITS) - 32'd1);
    localparam logic [LW:0] SLOT_LOG_L  = (LW+1)'(SLOT_LOG);
    localparam logic [LW:0] ADDR_BITS_L = (LW+1)'(ADDR_BITS);

    // Bits of an address below a 2^lg boundary
    function automatic logic [AW-1:0] low_mask(input logic [LW-1:0] lg);
        logic [AW-1:0] m;
        m = '0;
        for (int k = 0; k < AW; k++)
        begin
            m[k] = (LW'(k) < lg);
        end
        return m;
    endfunction

    // Request latch
    logic                            cmd_reg;
    logic [AW-1:0]                   addr_reg;
    logic [bste_pkg::NBYTES_W-1:0]   nbytes_reg;

    // Fill plan
    logic [bste_pkg::STATUS_W-1:0]   status_reg;
    logic [LW-1:0]                   log_reg;
    logic [AW-1:0]                   base_reg;
    logic [IDX_BITS-1:0]             span_reg;
    logic [IDX_BITS-1:0]             first_reg;
    logic [LW-1:0]                   val_reg;

    // Slot counter
    logic [IDX_BITS-1:0]             cnt_reg;
    logic [IDX_BITS-1:0]             cnt_next;

    // Response register
    logic [bste_pkg::STATUS_W-1:0]   out_status_reg;
    logic [LW-1:0]                   out_log_reg;
    logic [AW-1:0]                   out_base_reg;

    // Table ports
    logic                            wr_en;
    logic [IDX_BITS-1:0]             wr_addr;
    logic [LW-1:0]                   wr_data;
    logic [IDX_BITS-1:0]             rd_addr;
    logic [LW-1:0]                   rd_data;

    // Decode signals
    logic [bste_pkg::NBYTES_W-1:0]   n_m1;
    logic [LW-1:0]                   lg_raw;
    logic [LW-1:0]                   reg_lg;
    logic                            misaligned;
    logic [LW-1:0]                   ent_lg;
    logic                            unreg_none;
    logic [LW-1:0]                   sel_lg;
    logic [AW-1:0]                   sel_base;
    logic                            fault;
    logic [bste_pkg::STATUS_W-1:0]   sel_status;
    logic [IDX_BITS-1:0]             sel_span;

    // Register: ceiling log2 of the byte count, raised to one slot
    always_comb
    begin
        n_m1   = (nbytes_reg == '0) ? '0 : nbytes_reg - 1'b1;
        lg_raw = '0;
        for (int i = 0; i < bste_pkg::NBYTES_W; i++)
        begin
            if (n_m1[i])
            begin
                lg_raw = LW'(i + 1);
            end
        end
        reg_lg     = ({1'b0, lg_raw} < SLOT_LOG_L) ? SLOT_LOG_L[LW-1:0] : lg_raw;
        misaligned = ({1'b0, reg_lg} > ADDR_BITS_L) || ((addr_reg & low_mask(reg_lg)) != '0);
    end

    // Unregister: clamp the stored log size into the legal range
    always_comb
    begin
        unreg_none = (rd_data == '0);
        ent_lg     = rd_data;
        if ({1'b0, ent_lg} < SLOT_LOG_L)
        begin
            ent_lg = SLOT_LOG_L[LW-1:0];
        end
        if ({1'b0, ent_lg} > ADDR_BITS_L)
        begin
            ent_lg = ADDR_BITS_L[LW-1:0];
        end
    end

    // Select the plan for this command
    always_comb
    begin
        if (cmd_reg == bste_pkg::CMD_UNREGISTER)
        begin
            sel_lg     = ent_lg;
            sel_base   = addr_reg & ~low_mask(ent_lg);
            fault      = unreg_none;
            sel_status = unreg_none ? bste_pkg::STATUS_NOT_REG : bste_pkg::STATUS_DONE;
        end
        else
        begin
            sel_lg     = reg_lg;
            sel_base   = addr_reg;
            fault      = misaligned;
            sel_status = misaligned ? bste_pkg::STATUS_MISALIGNED : bste_pkg::STATUS_DONE;
        end
        for (int k = 0; k < IDX_BITS; k++)
        begin
            sel_span[k] = ((LW+1)'(k + SLOT_LOG) < {1'b0, sel_lg});
        end
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg    <= req_cmd;
            addr_reg   <= req_address & ADDR_MASK;
            nbytes_reg <= req_num_bytes;
        end
    end

    // Latch the fill plan
    always_ff @(posedge clk)
    begin
        if (ctl.eval)
        begin
            status_reg <= sel_status;
            log_reg    <= fault ? '0 : sel_lg;
            base_reg   <= fault ? '0 : sel_base;
            span_reg   <= sel_span;
            first_reg  <= IDX_BITS'(sel_base >> SLOT_LOG);
            val_reg    <= (cmd_reg == bste_pkg::CMD_UNREGISTER) ? '0 : reg_lg;
        end
    end

    // Slot counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (ctl.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Hold the response until taken
    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_status_reg <= status_reg;
            out_log_reg    <= log_reg;
            out_base_reg   <= base_reg;
        end
    end

    // Table access
    assign wr_en   = ctl.fill_wr | ctl.sweep_wr;
    assign wr_addr = ctl.sweep_wr ? cnt_reg : first_reg + cnt_reg;
    assign wr_data = ctl.sweep_wr ? '0 : val_reg;
    assign rd_addr = IDX_BITS'((req_address & ADDR_MASK) >> SLOT_LOG);

    bste_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Status to the controller
    always_comb
    begin
        sts.fault      = fault;
        sts.fill_last  = (cnt_reg == span_reg);
        sts.sweep_last = (cnt_reg == {IDX_BITS{1'b1}});
    end

    assign rsp_status       = out_status_reg;
    assign rsp_size_log     = out_log_reg;
    assign rsp_base_address = out_base_reg;

endmodule

`default_nettype wire

FILE: rtl/bste_chk.sv
// ----------------------------------------------------------------------------
// bste_chk
// Port-level checks of the size-table engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bste_chk #(
    parameter int SLOT_LOG = 4
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_ready,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [bste_pkg::STATUS_W-1:0]     rsp_status,
    input wire logic [bste_pkg::LOG_W-1:0]        rsp_size_log,
    input wire logic [bste_pkg::ADDR_W-1:0]       rsp_base_address
);

    // A pending response stays until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // One request at a time: no intake in the cycle after an acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is in progress");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == bste_pkg::STATUS_DONE ||
                       rsp_status == bste_pkg::STATUS_MISALIGNED ||
                       rsp_status == bste_pkg::STATUS_NOT_REG))
        else $error("undefined response status");

    // A refused request reports no object
    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != bste_pkg::STATUS_DONE
        |-> rsp_size_log == '0 && rsp_base_address == '0)
        else $error("refused request reports an object");

    // A completed request covers at least one slot
    a_done_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == bste_pkg::STATUS_DONE
        |-> rsp_size_log >= bste_pkg::LOG_W'(SLOT_LOG))
        else $error("completed request smaller than one slot");

endmodule

bind bounds_size_table_engine bste_chk #(
    .SLOT_LOG (SLOT_LOG)
) u_bste_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_size_log     (rsp.size_log),
    .rsp_base_address (rsp.base_address)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the size-table engine. A queue of directed and
// random register/unregister requests feeds a bursty driver. A local table
// model predicts every response, and a monitor compares each response field
// by field against the oldest prediction while the response side stalls at
// random, with one long hold-off that backs the engine up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ADDR_BITS      = 16;
    localparam int SLOT_LOG       = 4;
    localparam int SLOT_COUNT     = 1 << (ADDR_BITS - SLOT_LOG);
    localparam int RANDOM_CMDS    = 1100;
    localparam int LIVE_MAX       = 64;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLDOFF_AFTER  = 300;
    localparam int HOLDOFF_CYCLES = 500;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic                          cmd;
        logic [bste_pkg::ADDR_W-1:0]   address;
        logic [bste_pkg::NBYTES_W-1:0] num_bytes;
    } table_cmd_t;

    typedef struct packed {
        logic [bste_pkg::STATUS_W-1:0] status;
        logic [bste_pkg::LOG_W-1:0]    size_log;
        logic [bste_pkg::ADDR_W-1:0]   base_address;
    } table_result_t;

    logic clk;
    logic rst_n;

    bste_req_if req_ch ();
    bste_rsp_if rsp_ch ();

    bounds_size_table_engine #(
        .ADDR_BITS (ADDR_BITS),
        .SLOT_LOG  (SLOT_LOG)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Requests still to be offered, and responses predicted but not yet seen
    table_cmd_t    cmd_queue [$];
    table_result_t result_queue [$];

    // Local copy of the size table
    logic [bste_pkg::LOG_W-1:0] slot_log_model [SLOT_COUNT];

    // Objects registered by the random generator, used to aim unregisters
    int live_base [$];
    int live_log [$];

    table_cmd_t    taken_cmd;
    table_result_t observed_result;
    table_result_t expected_result;

    int unsigned cmds_taken;
    int          err_count;
    int unsigned idle_cycles;
    int          burst_left;
    int          gap_left;
    int          ready_pct;
    int          pct_hold;
    int          holdoff_left;
    bit          holdoff_done;

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Write one log size into every slot covered by an object
    function automatic void write_object_slots(int base, int lg, int val);
        int first;
        int count;
        first = base >> SLOT_LOG;
        count = 1 << (lg - SLOT_LOG);
        for (int i = 0; i < count; i++)
        begin
            if (first + i < SLOT_COUNT)
                slot_log_model[first + i] = val[bste_pkg::LOG_W-1:0];
        end
    endfunction

    // Apply one request to the table model and return its response
    function automatic table_result_t apply_table_cmd(table_cmd_t c);
        table_result_t r;
        int            a;
        int            lg;
        int            e;
        int            base;
        r = '0;
        r.status = bste_pkg::STATUS_DONE;
        a = c.address;
        if (c.cmd == bste_pkg::CMD_REGISTER)
        begin
            // ceiling log2 of the byte count, raised to one slot
            lg = 0;
            while (lg < 31 && (1 << lg) < c.num_bytes)
                lg++;
            if (lg < SLOT_LOG)
                lg = SLOT_LOG;
            if (lg > ADDR_BITS || (a & ((1 << lg) - 1)) != 0)
                r.status = bste_pkg::STATUS_MISALIGNED;
            else
            begin
                write_object_slots(a, lg, lg);
                r.size_log     = lg[bste_pkg::LOG_W-1:0];
                r.base_address = c.address;
            end
        end
        else
        begin
            e = slot_log_model[a >> SLOT_LOG];
            if (e == 0)
                r.status = bste_pkg::STATUS_NOT_REG;
            else
            begin
                if (e < SLOT_LOG)
                    e = SLOT_LOG;
                if (e > ADDR_BITS)
                    e = ADDR_BITS;
                base = a & ~((1 << e) - 1);
                write_object_slots(base, e, 0);
                r.size_log     = e[bste_pkg::LOG_W-1:0];
                r.base_address = base[bste_pkg::ADDR_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic queue_cmd(logic op, int address, int num_bytes);
        table_cmd_t c;
        c.cmd       = op;
        c.address   = address[bste_pkg::ADDR_W-1:0];
        c.num_bytes = num_bytes[bste_pkg::NBYTES_W-1:0];
        cmd_queue.push_back(c);
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        int kind;
        int lg;
        int addr;
        int nbytes;
        int pick;

        req_ch.valid     = 1'b0;
        req_ch.cmd       = bste_pkg::CMD_REGISTER;
        req_ch.address   = '0;
        req_ch.num_bytes = '0;
        rsp_ch.ready     = 1'b0;
        rst_n            = 1'b0;
        foreach (slot_log_model[i])
            slot_log_model[i] = '0;

        // Directed: free slot, tiny counts, alignment, edges of memory
        queue_cmd(bste_pkg::CMD_UNREGISTER, 'h0000, 'h0000);
        queue_cmd(bste_pkg::CMD_REGISTER,   'h0000, 'h0000);
        queue_cmd(bste_pkg::CMD_REGISTER,   'h0010, 'h0001);
        queue_cmd(bste_pkg::CMD_REGISTER,   'h0020, 'h0010);
        queue_cmd(bste_pkg::CMD_REGISTER,   'h0040, 'h0011);
        queue_cmd(bste_pkg::CMD_REGISTER,   'h0030, 'h0011);
        queue_cmd(bste_pkg::CMD_REGISTER,   'hFFF0, 'h0010);
        queue_cmd(bste_pkg::CMD_UNREGISTER, 'hFFFF, 'hFFFF);
        queue_cmd(bste_pkg::CMD_REGISTER,   'h0100, 'h0100);
        queue_cmd(bste_pkg::CMD_UNREGISTER, 'h01A7, 'h0000);
        // Overlap: small object written over the head of a larger one
        queue_cmd(bste_pkg::CMD_REGISTER,   'h0200, 'h0200);
        queue_cmd(bste_pkg::CMD_REGISTER,   'h0200, 'h0010);
        queue_cmd(bste_pkg::CMD_UNREGISTER, 'h0210, 'h0000);
        queue_cmd(bste_pkg::CMD_UNREGISTER, 'h0200, 'h0000);
        // Whole memory as one object, then cleared from the middle
        queue_cmd(bste_pkg::CMD_REGISTER,   'h0000, 'hFFFF);
        queue_cmd(bste_pkg::CMD_UNREGISTER, 'h8123, 'h0000);
        queue_cmd(bste_pkg::CMD_REGISTER,   'h8000, 'h8000);
        queue_cmd(bste_pkg::CMD_REGISTER,   'h4000, 'h8001);
        queue_cmd(bste_pkg::CMD_UNREGISTER, 'hC000, 'h0000);
        queue_cmd(bste_pkg::CMD_REGISTER,   'hFFFF, 'hFFFF);
        queue_cmd(bste_pkg::CMD_UNREGISTER, 'h0050, 'hAAAA);
        queue_cmd(bste_pkg::CMD_UNREGISTER, 'h0020, 'h5555);

        // Random: mostly aligned registers and unregisters aimed at live objects
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    lg = $urandom_range(SLOT_LOG, 8);
                else if (pick < 97)
                    lg = $urandom_range(9, 11);
                else
                    lg = $urandom_range(12, ADDR_BITS);
                if (lg == SLOT_LOG)
                    nbytes = $urandom_range(0, 1 << SLOT_LOG);
                else
                    nbytes = $urandom_range((1 << (lg - 1)) + 1,
                                            (lg == 16) ? 65535 : (1 << lg));
                addr = $urandom_range(0, 65535);
                // crowd most objects into a small window so they overlap
                if ($urandom_range(0, 99) < 60)
                    addr = addr & 'h0FFF;
                addr = addr & ~((1 << lg) - 1);
                queue_cmd(bste_pkg::CMD_REGISTER, addr, nbytes);
                live_base.push_back(addr);
                live_log.push_back(lg);
                if (live_base.size() > LIVE_MAX)
                begin
                    void'(live_base.pop_front());
                    void'(live_log.pop_front());
                end
            end
            else if (kind < 80)
            begin
                if (live_base.size() == 0)
                    addr = $urandom_range(0, 65535);
                else
                begin
                    pick = $urandom_range(0, live_base.size() - 1);
                    addr = live_base[pick] + $urandom_range(0, (1 << live_log[pick]) - 1);
                    live_base.delete(pick);
                    live_log.delete(pick);
                end
                queue_cmd(bste_pkg::CMD_UNREGISTER, addr, $urandom_range(0, 65535));
            end
            else if (kind < 88)
            begin
                lg     = $urandom_range(5, 10);
                nbytes = $urandom_range((1 << (lg - 1)) + 1, 1 << lg);
                addr   = $urandom_range(0, 65535);
                if ((addr & ((1 << lg) - 1)) == 0)
                    addr = addr | (1 << $urandom_range(0, lg - 1));
                queue_cmd(bste_pkg::CMD_REGISTER, addr, nbytes);
            end
            else
                queue_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go in and every response to come back
        while (cmd_queue.size() != 0 || req_ch.valid || result_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Driver: offer queued requests in bursts, hold each until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.cmd       <= bste_pkg::CMD_REGISTER;
            req_ch.address   <= '0;
            req_ch.num_bytes <= '0;
            burst_left       <= 0;
            gap_left         <= 0;
            cmds_taken       <= 0;
        end
        else
        begin
            // predict the response of a request as it is taken
            if (req_ch.valid && req_ch.ready)
            begin
                taken_cmd.cmd       = req_ch.cmd;
                taken_cmd.address   = req_ch.address;
                taken_cmd.num_bytes = req_ch.num_bytes;
                result_queue.push_back(apply_table_cmd(taken_cmd));
                cmds_taken <= cmds_taken + 1;
            end

            if (req_ch.valid && !req_ch.ready)
            begin
                // hold the request until it is taken
            end
            else if (gap_left != 0)
            begin
                gap_left     <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (cmd_queue.size() != 0)
            begin
                taken_cmd = cmd_queue.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.cmd       <= taken_cmd.cmd;
                req_ch.address   <= taken_cmd.address;
                req_ch.num_bytes <= taken_cmd.num_bytes;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Long response hold-off, once, partway through the random part
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else if (!holdoff_done && cmds_taken >= HOLDOFF_AFTER)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Response ready: random stall rate that changes every so often
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            ready_pct    <= 100;
            pct_hold     <= 0;
        end
        else
        begin
            if (pct_hold == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pct <= 100;
                    1:       ready_pct <= 70;
                    2:       ready_pct <= 40;
                    default: ready_pct <= 10;
                endcase
                pct_hold <= $urandom_range(20, 120);
            end
            else
                pct_hold <= pct_hold - 1;

            if (holdoff_left != 0)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Monitor: compare each response with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            observed_result.status       = rsp_ch.status;
            observed_result.size_log     = rsp_ch.size_log;
            observed_result.base_address = rsp_ch.base_address;
            if (result_queue.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("ERROR: unexpected response status=%0d size_log=%0d base=%h",
                             observed_result.status, observed_result.size_log,
                             observed_result.base_address);
            end
            else
            begin
                expected_result = result_queue.pop_front();
                if (observed_result !== expected_result)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("ERROR: response mismatch: expected status=%0d size_log=%0d base=%h",
                                 expected_result.status, expected_result.size_log,
                                 expected_result.base_address);
                        $display("       got status=%0d size_log=%0d base=%h",
                                 observed_result.status, observed_result.size_log,
                                 observed_result.base_address);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no request or response moved for %0d cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
